/* src/bsa_pkg.sv */
// ----------------------------------------------------------------------------
// bsa_pkg: shared definitions for the bitmap slot allocator
// Field widths, request and status codes, default geometry and the flag
// bundle between the word scan unit and the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bsa_pkg;

	localparam int unsigned POOL_SLOTS_DEF = 1024;
	localparam int unsigned WORD_BITS_DEF  = 64;

	localparam int unsigned OP_W  = 2;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned AMT_W = 11;
	localparam int unsigned ST_W  = 3;
	localparam int unsigned ACT_W = 11;
	localparam int unsigned CAP_W = 11;

	typedef logic [OP_W-1:0]  op_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [AMT_W-1:0] amt_t;
	typedef logic [ST_W-1:0]  status_t;
	typedef logic [ACT_W-1:0] act_t;
	typedef logic [CAP_W-1:0] cap_t;

	localparam cap_t CAP_RESET = 11'd1024;

	localparam op_t OP_ALLOC = 2'd0;
	localparam op_t OP_FREE  = 2'd1;
	localparam op_t OP_GROW  = 2'd2;

	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_NO_FREE = 3'd1;
	localparam status_t ST_RANGE   = 3'd2;
	localparam status_t ST_NOT_SET = 3'd3;
	localparam status_t ST_NO_ROOM = 3'd4;

	// found: a live clear bit exists in the word
	// stop:  the live region ends inside (or before) this word
	typedef struct packed {
		logic found;
		logic stop;
	} scan_flags_t;

endpackage

`default_nettype wire

/* src/bsa_if.sv */
// ----------------------------------------------------------------------------
// bsa_if: request and response channels of the bitmap slot allocator
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsa_req_if;
	import bsa_pkg::*;

	logic valid;
	logic ready;
	op_t  operation;
	idx_t slot_index;
	amt_t grow_amount;

	modport source (output valid, output operation, output slot_index,
		output grow_amount, input ready);
	modport sink (input valid, input operation, input slot_index,
		input grow_amount, output ready);
endinterface

interface bsa_rsp_if;
	import bsa_pkg::*;

	logic    valid;
	logic    ready;
	status_t status;
	idx_t    granted_slot;
	act_t    active_after;

	modport source (output valid, output status, output granted_slot,
		output active_after, input ready);
	modport sink (input valid, input status, input granted_slot,
		input active_after, output ready);
endinterface

`default_nettype wire

/* src/bsa_scan_unit.sv */
// ----------------------------------------------------------------------------
// bsa_scan_unit: lowest live clear bit of one bitmap word
// Masks off bits at or above the active count, isolates the lowest clear
// bit with a two's complement trick and encodes its position.
// ----------------------------------------------------------------------------
`default_nettype none

module bsa_scan_unit #(
	parameter  int unsigned WORD_BITS = bsa_pkg::WORD_BITS_DEF,
	parameter  int unsigned SLOT_W    = 11,
	localparam int unsigned BIT_W     = $clog2(WORD_BITS)
) (
	input  logic [WORD_BITS-1:0] word,
	input  logic [SLOT_W-1:0]    base,
	input  bsa_pkg::act_t        active,
	output bsa_pkg::scan_flags_t flags,
	output logic [WORD_BITS-1:0] onehot,
	output logic [BIT_W-1:0]     bit_idx
);
	import bsa_pkg::*;

	localparam int unsigned CW = ((SLOT_W > ACT_W) ? SLOT_W : ACT_W) + 1;

	logic [CW-1:0]        rem;
	logic [WORD_BITS-1:0] live;
	logic [WORD_BITS-1:0] clr;

	always_comb begin
		// slots of this word still below the active count
		rem = (CW'(active) > CW'(base)) ? (CW'(active) - CW'(base)) : '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			live[b] = rem > CW'(b);
		end
		clr    = ~word & live;
		onehot = clr & (~clr + WORD_BITS'(1));
		flags.found = |clr;
		flags.stop  = rem <= CW'(WORD_BITS);
		bit_idx = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			if (onehot[b]) begin
				bit_idx = bit_idx | BIT_W'(b);
			end
		end
	end

endmodule

`default_nettype wire

/* src/bitmap_slot_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_slot_allocator: first-fit slot allocator over a bitmap
// Sequencer around one word memory and one word scan unit.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one beat per request (allocate, free, grow). rsp channel:
//    exactly one beat per request, in order. cfg_wr_en/cfg_wr_data write the
//    capacity register; write it only while no request is in flight.
//  - Allocate reads bitmap words from word 0 upward, one word per cycle,
//    until the scan unit finds a live clear bit or the active region ends.
//    The sequencer accepts, scans and then hands over a response; at most
//    POOL/WORD_BITS words are read (16 by default). req.ready returns the
//    cycle after the response is loaded.
//  - Free steps a word pointer up to the word of slot_index (one word per
//    cycle), reads it, checks and clears the bit if it is set.
//    Out-of-range frees, grows and unused codes go straight to S_RESP.
//  - The memory read port is the limit: one word per cycle.
//  - Reset clears the active count, restores capacity to 1024 and zeroes a
//    word fill mark; words at or above the mark read as all free, so no
//    clearing pass is needed and the block is ready right after reset.
//  - A stalled rsp holds its beat in the output register; the next request
//    is still taken and its result waits in the sequencer until rsp frees.
//  - POOL_SLOTS must be a multiple of WORD_BITS.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_slot_allocator #(
	parameter int unsigned POOL_SLOTS = bsa_pkg::POOL_SLOTS_DEF,
	parameter int unsigned WORD_BITS  = bsa_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  bsa_pkg::cap_t cfg_wr_data,
	bsa_req_if.sink       req,
	bsa_rsp_if.source     rsp
);
	import bsa_pkg::*;

	localparam int unsigned WORD_COUNT = POOL_SLOTS / WORD_BITS;
	localparam int unsigned WI         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int unsigned HW_W       = $clog2(WORD_COUNT + 1);
	localparam int unsigned SLOT_W     = $clog2(POOL_SLOTS + 1);
	localparam int unsigned BIT_W      = $clog2(WORD_BITS);
	localparam int unsigned CMP_W      = ((SLOT_W > ACT_W) ? SLOT_W : ACT_W) + 2;

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;  // allocate: check one word a cycle
	localparam logic [2:0] S_SEEK = 3'd2;  // free: walk to the target word
	localparam logic [2:0] S_FCHK = 3'd3;  // free: test and clear the bit
	localparam logic [2:0] S_RESP = 3'd4;  // hand result to output register

	logic [2:0]           state_q;
	logic [WI-1:0]        w_q;        // current word
	logic [SLOT_W-1:0]    base_q;     // first slot of current word
	idx_t                 idx_q;
	logic [BIT_W-1:0]     off_q;      // bit of the slot being freed
	logic [HW_W-1:0]      hw_q;       // words below this were written at least once
	act_t                 active_q;
	cap_t                 capacity_q;
	logic                 rd_fill_q;  // read word lies below the fill mark

	status_t              pend_status_q;
	idx_t                 pend_slot_q;
	act_t                 pend_active_q;

	logic                 rsp_valid_q;
	status_t              rsp_status_q;
	idx_t                 rsp_slot_q;
	act_t                 rsp_active_q;

	logic [WORD_BITS-1:0] mem [WORD_COUNT];
	logic [WORD_BITS-1:0] rdata_q;

	logic                 accept;
	logic                 rsp_load;
	logic                 rd_en;
	logic [WI-1:0]        rd_addr;
	logic                 mem_we;
	logic [WORD_BITS-1:0] wr_data;
	logic                 last_w;
	logic [WORD_BITS-1:0] scan_word;
	logic                 seek_hit;
	logic                 free_bit;
	logic                 idx_bad;
	logic [CMP_W-1:0]     grow_sum;
	logic [CMP_W-1:0]     limit;
	logic [CMP_W-1:0]     grant_ext;

	scan_flags_t          flags;
	logic [WORD_BITS-1:0] onehot;
	logic [BIT_W-1:0]     bit_idx;

	assign req.ready        = (state_q == S_IDLE);
	assign accept           = req.valid && req.ready;
	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.granted_slot = rsp_slot_q;
	assign rsp.active_after = rsp_active_q;

	// result moves to the output register once that register is free
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	// word beyond the fill mark has never been written: treat as free
	assign scan_word = rd_fill_q ? rdata_q : '0;
	assign last_w    = (w_q == WI'(WORD_COUNT - 1));

	bsa_scan_unit #(
		.WORD_BITS (WORD_BITS),
		.SLOT_W    (SLOT_W)
	) u_scan (
		.word    (scan_word),
		.base    (base_q),
		.active  (active_q),
		.flags   (flags),
		.onehot  (onehot),
		.bit_idx (bit_idx)
	);

	always_comb begin
		seek_hit  = CMP_W'(idx_q) < (CMP_W'(base_q) + CMP_W'(WORD_BITS));
		free_bit  = rd_fill_q & rdata_q[off_q];
		idx_bad   = (CMP_W'(req.slot_index) >= CMP_W'(active_q)) ||
			(CMP_W'(req.slot_index) >= CMP_W'(POOL_SLOTS));
		grow_sum  = CMP_W'(active_q) + CMP_W'(req.grow_amount);
		limit     = (CMP_W'(capacity_q) < CMP_W'(POOL_SLOTS)) ?
			CMP_W'(capacity_q) : CMP_W'(POOL_SLOTS);
		grant_ext = CMP_W'(base_q) + CMP_W'(bit_idx);
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = w_q;
		mem_we  = 1'b0;
		wr_data = scan_word | onehot;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.operation == OP_ALLOC) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			S_SCAN: begin
				if (flags.found) begin
					mem_we = 1'b1;
				end else if (!flags.stop && !last_w) begin
					rd_en   = 1'b1;
					rd_addr = w_q + WI'(1);
				end
			end
			S_SEEK: begin
				rd_en = seek_hit;
			end
			S_FCHK: begin
				mem_we  = free_bit;
				wr_data = rdata_q & ~(WORD_BITS'(1) << off_q);
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[w_q] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			w_q           <= '0;
			base_q        <= '0;
			idx_q         <= '0;
			off_q         <= '0;
			hw_q          <= '0;
			active_q      <= '0;
			capacity_q    <= CAP_RESET;
			rd_fill_q     <= 1'b0;
			pend_status_q <= ST_OK;
			pend_slot_q   <= '0;
			pend_active_q <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_status_q  <= ST_OK;
			rsp_slot_q    <= '0;
			rsp_active_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				capacity_q <= cfg_wr_data;
			end
			if (rd_en) begin
				rd_fill_q <= HW_W'(rd_addr) < hw_q;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						w_q         <= '0;
						base_q      <= '0;
						idx_q       <= req.slot_index;
						pend_slot_q <= '0;
						unique case (req.operation)
							OP_ALLOC: begin
								pend_status_q <= ST_OK;
								pend_active_q <= active_q;
								state_q       <= S_SCAN;
							end
							OP_FREE: begin
								pend_active_q <= active_q;
								if (idx_bad) begin
									pend_status_q <= ST_RANGE;
									state_q       <= S_RESP;
								end else begin
									pend_status_q <= ST_OK;
									state_q       <= S_SEEK;
								end
							end
							OP_GROW: begin
								if (grow_sum <= limit) begin
									active_q      <= grow_sum[ACT_W-1:0];
									pend_active_q <= grow_sum[ACT_W-1:0];
									pend_status_q <= ST_OK;
								end else begin
									pend_active_q <= active_q;
									pend_status_q <= ST_NO_ROOM;
								end
								state_q <= S_RESP;
							end
							default: begin
								// unused code: no-op
								pend_status_q <= ST_OK;
								pend_active_q <= active_q;
								state_q       <= S_RESP;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (flags.found) begin
						pend_slot_q <= grant_ext[IDX_W-1:0];
						// first write to a fresh word advances the fill mark
						if (!rd_fill_q) begin
							hw_q <= hw_q + HW_W'(1);
						end
						state_q <= S_RESP;
					end else if (flags.stop || last_w) begin
						pend_status_q <= ST_NO_FREE;
						state_q       <= S_RESP;
					end else begin
						w_q    <= w_q + WI'(1);
						base_q <= base_q + SLOT_W'(WORD_BITS);
					end
				end
				S_SEEK: begin
					if (seek_hit) begin
						off_q   <= BIT_W'(CMP_W'(idx_q) - CMP_W'(base_q));
						state_q <= S_FCHK;
					end else begin
						w_q    <= w_q + WI'(1);
						base_q <= base_q + SLOT_W'(WORD_BITS);
					end
				end
				S_FCHK: begin
					if (!free_bit) begin
						pend_status_q <= ST_NOT_SET;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						rsp_status_q <= pend_status_q;
						rsp_slot_q   <= pend_slot_q;
						rsp_active_q <= pend_active_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------------
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("request taken while a request is in flight");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= HW_W'(WORD_COUNT))
		else $error("fill mark beyond word count");

	a_write_below_mark: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (HW_W'(w_q) <= hw_q))
		else $error("bitmap write skips past the fill mark");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(active_q) <= CMP_W'(POOL_SLOTS))
		else $error("active count above pool size");

endmodule

`default_nettype wire
